### rtl/core/rstt_pkg.sv
// Shared types, constants and request codes for the relay schedule table timer.
package rstt_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int SLOT_W      = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

	localparam int TIME_W  = 18;
	localparam int ETIME_W = 17;
	localparam int AOFF_W  = 11;
	localparam int DATE_W  = 27;
	localparam int REQ_W   = 3;
	localparam int REP_W   = 3;
	localparam int WDAY_W  = 3;
	localparam int PROD_W  = 17;

	// request codes
	localparam logic [REQ_W-1:0] REQ_LOAD      = 3'd0;
	localparam logic [REQ_W-1:0] REQ_SCHED     = 3'd1;
	localparam logic [REQ_W-1:0] REQ_AUTO_OFF  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_SET_EXP   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_CLEAR_EXP = 3'd4;

	// repeat kinds
	localparam logic [REP_W-1:0] REP_ONCE     = 3'd0;
	localparam logic [REP_W-1:0] REP_DAILY    = 3'd1;
	localparam logic [REP_W-1:0] REP_WEEKENDS = 3'd2;
	localparam logic [REP_W-1:0] REP_WEEKDAYS = 3'd3;

	// weekday codes that count as weekend
	localparam logic [WDAY_W-1:0] WDAY_SUN = 3'd0;
	localparam logic [WDAY_W-1:0] WDAY_SAT = 3'd6;

	// result causes
	localparam logic CAUSE_SCHED    = 1'b0;
	localparam logic CAUSE_AUTO_OFF = 1'b1;

	localparam logic [TIME_W:0]   WINDOW_SEC  = 19'd5;
	localparam logic [5:0]        SEC_PER_MIN = 6'd60;
	localparam logic [TIME_W-1:0] EXPIRY_MAX  = 18'h3FFFF;

	// one table entry as loaded
	typedef struct packed {
		logic               active;
		logic [REP_W-1:0]   repeat_kind;
		logic               action_on;
		logic [ETIME_W-1:0] fire_time;
		logic [AOFF_W-1:0]  auto_off_min;
	} entry_t;

	// tick context broadcast to every cell
	typedef struct packed {
		logic [TIME_W-1:0] now;
		logic [DATE_W-1:0] today;
		logic              weekend;
	} query_t;

	// chain control from the sequencer
	typedef struct packed {
		logic shift;
		logic clr;
		logic take;
	} cell_ctl_t;

	// firing report of the cell holding the token
	typedef struct packed {
		logic              fire;
		logic              action_on;
		logic [AOFF_W-1:0] auto_off_min;
	} cell_hit_t;

endpackage

### rtl/core/rstt_cell.sv
// One table cell: holds an entry and its fired date, passes the scan token on.
module rstt_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rstt_pkg::cell_ctl_t             ctl,
	input  logic                            tok_in,
	output logic                            tok_out,
	input  logic                            wr,
	input  rstt_pkg::entry_t                wdata,
	input  rstt_pkg::query_t                qry,
	output rstt_pkg::cell_hit_t             hit
);

	logic                          tok_q;
	rstt_pkg::entry_t              entry_q;
	logic [rstt_pkg::DATE_W-1:0]   fired_q;
	logic                          rep_match;
	logic                          in_window;
	logic                          fire;

	// move the token along the chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.clr) begin
			tok_q <= 1'b0;
		end else if (ctl.shift) begin
			tok_q <= tok_in;
		end
	end

	assign tok_out = tok_q;

	// match the repeat kind against the day
	always_comb begin
		case (entry_q.repeat_kind)
			rstt_pkg::REP_ONCE:     rep_match = (fired_q == '0);
			rstt_pkg::REP_DAILY:    rep_match = 1'b1;
			rstt_pkg::REP_WEEKENDS: rep_match = qry.weekend;
			rstt_pkg::REP_WEEKDAYS: rep_match = !qry.weekend;
			default:                rep_match = 1'b0;
		endcase
	end

	// check the five-second window
	assign in_window = ({1'b0, qry.now} >= {2'b00, entry_q.fire_time}) &&
		({1'b0, qry.now} < ({2'b00, entry_q.fire_time} + rstt_pkg::WINDOW_SEC));

	assign fire = tok_q && entry_q.active && rep_match && (fired_q != qry.today) && in_window;

	assign hit.fire         = fire;
	assign hit.action_on    = fire & entry_q.action_on;
	assign hit.auto_off_min = fire ? entry_q.auto_off_min : '0;

	// load the entry, stamp the date on a firing
	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q <= wdata;
			fired_q <= '0;
		end else if (ctl.take && fire) begin
			fired_q <= qry.today;
		end
	end

endmodule

### rtl/core/relay_schedule_table_timer.sv
// Relay schedule table timer top level: request sequencer, cell chain and result register.
// Load, expiry and auto-off requests are handled in the idle state. On a schedule tick
// a scan token walks the chain of entry cells one cell per cycle unless a stalled result
// holds it, and each firing entry gives one result in slot order. The block takes one
// request at a time and accepts a new one once the tick's scan has ended and the
// result register can take a result. Results that find the output stalled hold the
// scan in place until the downstream side takes them.
module relay_schedule_table_timer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rstt_pkg::REQ_W-1:0]          req_type,
	input  logic [3:0]                          entry_index,
	input  logic                                entry_active,
	input  logic [rstt_pkg::REP_W-1:0]          entry_repeat,
	input  logic                                entry_action_on,
	input  logic [rstt_pkg::ETIME_W-1:0]        entry_time,
	input  logic [rstt_pkg::AOFF_W-1:0]         entry_auto_off_min,
	input  logic                                last_entry,
	input  logic [rstt_pkg::TIME_W-1:0]         time_value,
	input  logic                                time_valid,
	input  logic [rstt_pkg::DATE_W-1:0]         today_date,
	input  logic [rstt_pkg::WDAY_W-1:0]         weekday,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                relay_on,
	output logic                                cause,
	output logic [3:0]                          fired_slot,
	output logic                                last_result
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic                                   state_q;
	logic [rstt_pkg::CNT_W-1:0]             count_q;
	logic [rstt_pkg::CNT_W-1:0]             pos_q;
	logic [rstt_pkg::TIME_W-1:0]            expiry_q;
	logic                                   armed_q;
	rstt_pkg::query_t                       qry_q;

	logic                                   pend_v_q;
	logic                                   pend_on_q;
	logic [rstt_pkg::SLOT_W-1:0]            pend_slot_q;

	logic                                   out_v_q;
	logic                                   out_on_q;
	logic                                   out_cause_q;
	logic [rstt_pkg::SLOT_W-1:0]            out_slot_q;
	logic                                   out_last_q;

	logic                                   accept;
	logic                                   out_busy;
	logic                                   scan_end;
	logic                                   stall;
	logic                                   adv;
	logic                                   start;
	rstt_pkg::cell_ctl_t                    ctl;
	rstt_pkg::entry_t                       wdata;
	rstt_pkg::cell_hit_t                    hits [rstt_pkg::MAX_ENTRIES];
	rstt_pkg::cell_hit_t                    hit_any;
	logic [rstt_pkg::MAX_ENTRIES-1:0]       wr;
	logic [rstt_pkg::MAX_ENTRIES-1:0]       tok;
	logic [rstt_pkg::PROD_W-1:0]            aoff_sec;
	logic [rstt_pkg::TIME_W:0]              exp_sum;
	logic [rstt_pkg::TIME_W-1:0]            exp_new;

	// handshake
	assign out_busy = out_v_q && !out_ready;
	assign in_ready = (state_q == ST_IDLE) && !out_busy;
	assign accept   = in_valid && in_ready;
	assign start    = accept && (req_type == rstt_pkg::REQ_SCHED) && time_valid;

	// scan control
	assign scan_end = (pos_q == count_q) ||
		(pos_q == rstt_pkg::CNT_W'(rstt_pkg::MAX_ENTRIES));
	assign stall    = hit_any.fire && pend_v_q && out_busy;
	assign adv      = (state_q == ST_SCAN) && !scan_end && !stall;

	assign ctl.shift = adv || start;
	assign ctl.clr   = (state_q == ST_SCAN) && scan_end;
	assign ctl.take  = adv;

	// decode load writes
	assign wdata.active       = entry_active;
	assign wdata.repeat_kind  = entry_repeat;
	assign wdata.action_on    = entry_action_on;
	assign wdata.fire_time    = entry_time;
	assign wdata.auto_off_min = entry_auto_off_min;

	always_comb begin
		for (int i = 0; i < rstt_pkg::MAX_ENTRIES; i++) begin
			wr[i] = accept && (req_type == rstt_pkg::REQ_LOAD) &&
				(entry_index == rstt_pkg::SLOT_W'(i));
		end
	end

	// cell chain
	for (genvar g = 0; g < rstt_pkg::MAX_ENTRIES; g++) begin : g_cell
		logic tok_prev;
		if (g == 0) begin : g_head
			assign tok_prev = start;
		end else begin : g_body
			assign tok_prev = tok[g-1];
		end
		rstt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.tok_in (tok_prev),
			.tok_out(tok[g]),
			.wr     (wr[g]),
			.wdata  (wdata),
			.qry    (qry_q),
			.hit    (hits[g])
		);
	end

	// combine reports; only the token holder can fire
	always_comb begin
		hit_any = '0;
		for (int i = 0; i < rstt_pkg::MAX_ENTRIES; i++) begin
			hit_any = hit_any | hits[i];
		end
	end

	// expiry from auto-off minutes, saturated
	assign aoff_sec = {{(rstt_pkg::PROD_W - rstt_pkg::AOFF_W){1'b0}}, hit_any.auto_off_min} *
		rstt_pkg::SEC_PER_MIN;
	assign exp_sum  = {1'b0, qry_q.now} + {2'b00, aoff_sec};
	assign exp_new  = exp_sum[rstt_pkg::TIME_W] ? rstt_pkg::EXPIRY_MAX :
		exp_sum[rstt_pkg::TIME_W-1:0];

	// latch tick context
	always_ff @(posedge clk) begin
		if (start) begin
			qry_q.now     <= time_value;
			qry_q.today   <= today_date;
			qry_q.weekend <= (weekday == rstt_pkg::WDAY_SUN) || (weekday == rstt_pkg::WDAY_SAT);
		end
	end

	// sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			pos_q    <= '0;
			expiry_q <= '0;
			armed_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							rstt_pkg::REQ_LOAD: begin
								if (last_entry) begin
									count_q <= rstt_pkg::CNT_W'(entry_index) + 1'b1;
								end
							end
							rstt_pkg::REQ_SCHED: begin
								if (time_valid) begin
									state_q <= ST_SCAN;
									pos_q   <= '0;
								end
							end
							rstt_pkg::REQ_AUTO_OFF: begin
								if (armed_q && time_valid && (time_value >= expiry_q)) begin
									armed_q <= 1'b0;
									out_v_q <= 1'b1;
								end
							end
							rstt_pkg::REQ_SET_EXP: begin
								expiry_q <= time_value;
								armed_q  <= 1'b1;
							end
							rstt_pkg::REQ_CLEAR_EXP: begin
								armed_q <= 1'b0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						// flush the held result as the last one
						if (!pend_v_q) begin
							state_q <= ST_IDLE;
						end else if (!out_busy) begin
							out_v_q  <= 1'b1;
							pend_v_q <= 1'b0;
							state_q  <= ST_IDLE;
						end
					end else if (!stall) begin
						pos_q <= pos_q + 1'b1;
						if (hit_any.fire) begin
							pend_v_q <= 1'b1;
							if (hit_any.action_on && (hit_any.auto_off_min != '0)) begin
								expiry_q <= exp_new;
								armed_q  <= 1'b1;
							end
							if (pend_v_q) begin
								out_v_q <= 1'b1;
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload and held result
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			if (accept) begin
				out_on_q    <= 1'b0;
				out_cause_q <= rstt_pkg::CAUSE_AUTO_OFF;
				out_slot_q  <= '0;
				out_last_q  <= 1'b1;
			end
		end else if (scan_end) begin
			if (pend_v_q && !out_busy) begin
				out_on_q    <= pend_on_q;
				out_cause_q <= rstt_pkg::CAUSE_SCHED;
				out_slot_q  <= pend_slot_q;
				out_last_q  <= 1'b1;
			end
		end else if (!stall && hit_any.fire) begin
			pend_on_q   <= hit_any.action_on;
			pend_slot_q <= pos_q[rstt_pkg::SLOT_W-1:0];
			if (pend_v_q) begin
				out_on_q    <= pend_on_q;
				out_cause_q <= rstt_pkg::CAUSE_SCHED;
				out_slot_q  <= pend_slot_q;
				out_last_q  <= 1'b0;
			end
		end
	end

	assign out_valid   = out_v_q;
	assign relay_on    = out_on_q;
	assign cause       = out_cause_q;
	assign fired_slot  = out_slot_q;
	assign last_result = out_last_q;

endmodule
